// File: rtl/swzd_pkg.sv
// Package for the sliding-window z-score detector.
// Holds the fixed field widths, register indexes, controller state and the
// command/status structs shared by the controller, datapath and top level.
`default_nettype none

package swzd_pkg;

    // Fixed widths of the item and result fields
    localparam int FEATURE_W   = 3;
    localparam int SAMPLE_W    = 16;
    localparam int THR_W       = 8;
    localparam int THR_SQ_W    = 2 * THR_W;
    localparam int RUN_W       = 16;
    localparam int TOTAL_W     = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int LHS_SHIFT   = 8;

    // Reset value of both thresholds: 3.0 in unsigned Q4.4
    localparam logic [THR_W-1:0] THR_RESET = 8'd48;

    // Register indexes (taken from paddr[2])
    localparam logic REG_MODEL_THR = 1'b0;
    localparam logic REG_ALERT_THR = 1'b1;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_SQUARE,
        S_VAR,
        S_DEV,
        S_MODEL_LO,
        S_MODEL_HI,
        S_ALERT_LO,
        S_ALERT_HI,
        S_OUT
    } state_t;

    // Operand pair fed to the shared multiplier
    typedef enum logic [2:0] {
        MUL_DIFF_SQ,
        MUL_SUM_SQ,
        MUL_DEV_SQ,
        MUL_VLO_MODEL,
        MUL_VHI_MODEL,
        MUL_VLO_ALERT,
        MUL_VHI_ALERT
    } mul_sel_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic     load;
        logic     upd_window;
        logic     upd_square;
        logic     calc_var;
        logic     calc_lhs;
        logic     acc_low;
        logic     cmp_model;
        logic     cmp_alert;
        logic     emit;
        mul_sel_t mul_sel;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic feature_ok;
        logic out_busy;
    } status_t;

endpackage

`default_nettype wire

// File: rtl/swzd_stream_if.sv
// Valid/ready stream interfaces for the detector's item and result channels.
// Depends on swzd_pkg for the field widths.
`default_nettype none

interface swzd_item_if;
    logic                          valid;
    logic                          ready;
    logic [swzd_pkg::FEATURE_W-1:0] feature;
    logic [swzd_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output feature, output sample, input ready);
    modport sink   (input valid, input feature, input sample, output ready);
endinterface

interface swzd_result_if;
    logic                          valid;
    logic                          ready;
    logic [swzd_pkg::FEATURE_W-1:0] feature_echo;
    logic                          spread_present;
    logic                          model_anomaly;
    logic                          alert;
    logic [swzd_pkg::RUN_W-1:0]     run_length;
    logic [swzd_pkg::TOTAL_W-1:0]   anomaly_total;
    logic [swzd_pkg::SAMPLE_W-1:0]  smallest_seen;
    logic [swzd_pkg::SAMPLE_W-1:0]  largest_seen;

    modport source (output valid, output feature_echo, output spread_present,
                    output model_anomaly, output alert, output run_length,
                    output anomaly_total, output smallest_seen, output largest_seen,
                    input ready);
    modport sink   (input valid, input feature_echo, input spread_present,
                    input model_anomaly, input alert, input run_length,
                    input anomaly_total, input smallest_seen, input largest_seen,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/swzd_ctrl.sv
// Controller for the detector: steps one item through the shared multiplier.
// Depends on swzd_pkg for the state type and the command/status structs.
`default_nettype none

module swzd_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire swzd_pkg::status_t status,
    output swzd_pkg::cmd_t         cmd
);

    swzd_pkg::state_t state_reg;
    swzd_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swzd_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swzd_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    // An out-of-range feature skips the arithmetic entirely.
                    state_next = status.feature_ok ? swzd_pkg::S_READ : swzd_pkg::S_OUT;
                end
            end
            swzd_pkg::S_READ:     state_next = swzd_pkg::S_SQUARE;
            swzd_pkg::S_SQUARE:   state_next = swzd_pkg::S_VAR;
            swzd_pkg::S_VAR:      state_next = swzd_pkg::S_DEV;
            swzd_pkg::S_DEV:      state_next = swzd_pkg::S_MODEL_LO;
            swzd_pkg::S_MODEL_LO: state_next = swzd_pkg::S_MODEL_HI;
            swzd_pkg::S_MODEL_HI: state_next = swzd_pkg::S_ALERT_LO;
            swzd_pkg::S_ALERT_LO: state_next = swzd_pkg::S_ALERT_HI;
            swzd_pkg::S_ALERT_HI: state_next = swzd_pkg::S_OUT;
            swzd_pkg::S_OUT:
            begin
                if (!status.out_busy)
                begin
                    state_next = swzd_pkg::S_IDLE;
                end
            end
            default:              state_next = swzd_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd        = '0;
        cmd.mul_sel = swzd_pkg::MUL_DIFF_SQ;
        item_ready = 1'b0;
        unique case (state_reg)
            swzd_pkg::S_IDLE:
            begin
                item_ready = 1'b1;
                cmd.load   = item_valid;
            end
            swzd_pkg::S_READ:
            begin
                cmd.upd_window = 1'b1;
                cmd.mul_sel    = swzd_pkg::MUL_DIFF_SQ;
            end
            swzd_pkg::S_SQUARE:
            begin
                cmd.upd_square = 1'b1;
                cmd.mul_sel    = swzd_pkg::MUL_SUM_SQ;
            end
            swzd_pkg::S_VAR:
            begin
                cmd.calc_var = 1'b1;
                cmd.mul_sel  = swzd_pkg::MUL_DEV_SQ;
            end
            swzd_pkg::S_DEV:
            begin
                cmd.calc_lhs = 1'b1;
                cmd.mul_sel  = swzd_pkg::MUL_VLO_MODEL;
            end
            swzd_pkg::S_MODEL_LO:
            begin
                cmd.acc_low = 1'b1;
                cmd.mul_sel = swzd_pkg::MUL_VHI_MODEL;
            end
            swzd_pkg::S_MODEL_HI:
            begin
                cmd.cmp_model = 1'b1;
                cmd.mul_sel   = swzd_pkg::MUL_VLO_ALERT;
            end
            swzd_pkg::S_ALERT_LO:
            begin
                cmd.acc_low = 1'b1;
                cmd.mul_sel = swzd_pkg::MUL_VHI_ALERT;
            end
            swzd_pkg::S_ALERT_HI:
            begin
                cmd.cmp_alert = 1'b1;
            end
            swzd_pkg::S_OUT:
            begin
                cmd.emit = !status.out_busy;
            end
            default:
            begin
                cmd.load = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/swzd_datapath.sv
// Datapath of the detector: window memory, per-feature statistics, the
// shared multiplier, the threshold compares and the result register.
// Depends on swzd_pkg and the swzd_result_if interface.
`default_nettype none

module swzd_datapath #(
    parameter int WINDOW_DEPTH  = 128,
    parameter int FEATURE_COUNT = 8,
    parameter int SAMPLE_BITS   = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [swzd_pkg::FEATURE_W-1:0] feature,
    input  wire logic [swzd_pkg::SAMPLE_W-1:0]  sample,
    input  wire logic [swzd_pkg::THR_W-1:0]     model_threshold,
    input  wire logic [swzd_pkg::THR_W-1:0]     alert_threshold,
    input  wire swzd_pkg::cmd_t                 cmd,
    output swzd_pkg::status_t                   status,
    swzd_result_if.source                       result_ch
);

    localparam int SW     = (SAMPLE_BITS < swzd_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                               : swzd_pkg::SAMPLE_W;
    localparam int PW     = $clog2(WINDOW_DEPTH);
    localparam int FW     = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
    localparam int MAW    = $clog2(FEATURE_COUNT * WINDOW_DEPTH);
    localparam int SUM_W  = SW + PW;
    localparam int SQ_W   = 2 * SW + PW;
    localparam int VAR_W  = 2 * SUM_W;
    localparam int MW     = ((SUM_W > swzd_pkg::THR_SQ_W) ? SUM_W : swzd_pkg::THR_SQ_W) + 1;
    localparam int P_W    = 2 * MW;
    localparam int CMP_W  = VAR_W + swzd_pkg::THR_SQ_W;
    localparam logic [PW-1:0] POS_LAST = PW'(WINDOW_DEPTH - 1);

    // Per-feature statistics
    logic [SUM_W-1:0]           sum_reg     [FEATURE_COUNT];
    logic [SQ_W-1:0]            sq_reg      [FEATURE_COUNT];
    logic [PW-1:0]              pos_reg     [FEATURE_COUNT];
    logic                       wrapped_reg [FEATURE_COUNT];
    logic                       seen_reg    [FEATURE_COUNT];
    logic [SW-1:0]              min_reg     [FEATURE_COUNT];
    logic [SW-1:0]              max_reg     [FEATURE_COUNT];
    logic [swzd_pkg::RUN_W-1:0]   run_reg   [FEATURE_COUNT];
    logic [swzd_pkg::TOTAL_W-1:0] total_reg [FEATURE_COUNT];

    // Window memory
    logic [SW-1:0] window_mem [FEATURE_COUNT * WINDOW_DEPTH];

    // Item registers
    logic [swzd_pkg::FEATURE_W-1:0] feature_reg;
    logic                           ok_reg;
    logic [FW-1:0]                  fidx_reg;
    logic [SW-1:0]                  v_reg;
    logic                           seen_before_reg;
    logic [MAW-1:0]                 wr_addr_reg;
    logic [SW-1:0]                  rd_data_reg;

    // Working registers
    logic [SUM_W-1:0]        sum_w_reg;
    logic [SQ_W-1:0]         sq_w_reg;
    logic [SUM_W-1:0]        dev_reg;
    logic [VAR_W-1:0]        var_reg;
    logic                    var_nz_reg;
    logic [CMP_W-1:0]        lhs_reg;
    logic [CMP_W-1:0]        acc_reg;
    logic signed [P_W-1:0]   prod_reg;
    logic                    anom_reg;
    logic                    alert_reg;
    logic [swzd_pkg::THR_SQ_W-1:0] tm2_reg;
    logic [swzd_pkg::THR_SQ_W-1:0] ta2_reg;

    // Result register
    logic                           out_valid_reg;
    logic [swzd_pkg::FEATURE_W-1:0] out_feature_reg;
    logic                           out_spread_reg;
    logic                           out_anom_reg;
    logic                           out_alert_reg;
    logic [swzd_pkg::RUN_W-1:0]     out_run_reg;
    logic [swzd_pkg::TOTAL_W-1:0]   out_total_reg;
    logic [swzd_pkg::SAMPLE_W-1:0]  out_min_reg;
    logic [swzd_pkg::SAMPLE_W-1:0]  out_max_reg;

    logic                  feature_ok;
    logic [FW-1:0]         fidx_in;
    logic [MAW-1:0]        rd_addr;
    logic [SW-1:0]         old_val;
    logic signed [SW:0]    diff_s;
    logic [SW:0]           pair_sum;
    logic signed [MW-1:0]  mul_a;
    logic signed [MW-1:0]  mul_b;
    logic [SUM_W-1:0]      nv;
    logic [P_W-1:0]        sq_sum_full;
    logic [CMP_W-1:0]      rhs;
    logic                  spread;
    logic [swzd_pkg::RUN_W-1:0]   run_new;
    logic [swzd_pkg::TOTAL_W-1:0] total_new;

    // Decode of the incoming feature index
    assign feature_ok = (32'(feature) < FEATURE_COUNT);
    assign fidx_in    = feature_ok ? FW'(feature) : '0;
    assign rd_addr    = MAW'(fidx_in) * MAW'(WINDOW_DEPTH) + MAW'(pos_reg[fidx_in]);

    assign status.feature_ok = feature_ok;
    assign status.out_busy   = out_valid_reg & ~result_ch.ready;

    // The slot being replaced counts as zero until the window has wrapped once.
    assign old_val  = wrapped_reg[fidx_reg] ? rd_data_reg : '0;
    assign diff_s   = $signed({1'b0, v_reg}) - $signed({1'b0, old_val});
    assign pair_sum = {1'b0, v_reg} + {1'b0, old_val};
    assign nv       = SUM_W'(v_reg) * SUM_W'(WINDOW_DEPTH);
    assign sq_sum_full = P_W'($signed(P_W'(sq_reg[fidx_reg])) + prod_reg);
    assign rhs      = acc_reg + (CMP_W'($unsigned(prod_reg)) << SUM_W);

    // Operand selection for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            swzd_pkg::MUL_DIFF_SQ:
            begin
                mul_a = MW'(diff_s);
                mul_b = $signed(MW'(pair_sum));
            end
            swzd_pkg::MUL_SUM_SQ:
            begin
                mul_a = $signed(MW'(sum_w_reg));
                mul_b = $signed(MW'(sum_w_reg));
            end
            swzd_pkg::MUL_DEV_SQ:
            begin
                mul_a = $signed(MW'(dev_reg));
                mul_b = $signed(MW'(dev_reg));
            end
            swzd_pkg::MUL_VLO_MODEL:
            begin
                mul_a = $signed(MW'(var_reg[SUM_W-1:0]));
                mul_b = $signed(MW'(tm2_reg));
            end
            swzd_pkg::MUL_VHI_MODEL:
            begin
                mul_a = $signed(MW'(var_reg[VAR_W-1:SUM_W]));
                mul_b = $signed(MW'(tm2_reg));
            end
            swzd_pkg::MUL_VLO_ALERT:
            begin
                mul_a = $signed(MW'(var_reg[SUM_W-1:0]));
                mul_b = $signed(MW'(ta2_reg));
            end
            swzd_pkg::MUL_VHI_ALERT:
            begin
                mul_a = $signed(MW'(var_reg[VAR_W-1:SUM_W]));
                mul_b = $signed(MW'(ta2_reg));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Shared multiplier and threshold squares
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        tm2_reg  <= model_threshold * model_threshold;
        ta2_reg  <= alert_threshold * alert_threshold;
    end

    // Window memory: read at accept, written in the read step
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rd_data_reg <= window_mem[rd_addr];
        end
        if (cmd.upd_window)
        begin
            window_mem[wr_addr_reg] <= v_reg;
        end
    end

    // Item capture and arithmetic steps
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            feature_reg     <= feature;
            fidx_reg        <= fidx_in;
            v_reg           <= SW'(sample);
            seen_before_reg <= seen_reg[fidx_in];
            wr_addr_reg     <= rd_addr;
        end
        if (cmd.upd_window)
        begin
            sum_w_reg <= sum_reg[fidx_reg] - SUM_W'(old_val) + SUM_W'(v_reg);
        end
        if (cmd.upd_square)
        begin
            sq_w_reg <= sq_sum_full[SQ_W-1:0];
            dev_reg  <= (nv >= sum_w_reg) ? (nv - sum_w_reg) : (sum_w_reg - nv);
        end
        if (cmd.calc_var)
        begin
            var_reg <= VAR_W'(sq_w_reg) * VAR_W'(WINDOW_DEPTH)
                       - VAR_W'($unsigned(prod_reg));
        end
        if (cmd.calc_lhs)
        begin
            lhs_reg    <= CMP_W'($unsigned(prod_reg)) << swzd_pkg::LHS_SHIFT;
            var_nz_reg <= (var_reg != '0);
        end
        if (cmd.acc_low)
        begin
            acc_reg <= CMP_W'($unsigned(prod_reg));
        end
        if (cmd.cmp_model)
        begin
            anom_reg <= (lhs_reg > rhs);
        end
        if (cmd.cmp_alert)
        begin
            alert_reg <= (lhs_reg > rhs);
        end
    end

    // Counter update for the item being emitted
    always_comb
    begin
        spread    = ok_reg & seen_before_reg & var_nz_reg;
        run_new   = run_reg[fidx_reg];
        total_new = total_reg[fidx_reg];
        if (spread)
        begin
            if (anom_reg)
            begin
                if (run_new != '1)
                begin
                    run_new = run_new + 1'b1;
                end
                if (total_new != '1)
                begin
                    total_new = total_new + 1'b1;
                end
            end
            else
            begin
                run_new = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ok_reg <= feature_ok;
        end
    end

    // Per-feature statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FEATURE_COUNT; i++)
            begin
                sum_reg[i]     <= '0;
                sq_reg[i]      <= '0;
                pos_reg[i]     <= '0;
                wrapped_reg[i] <= 1'b0;
                seen_reg[i]    <= 1'b0;
                min_reg[i]     <= '0;
                max_reg[i]     <= '0;
                run_reg[i]     <= '0;
                total_reg[i]   <= '0;
            end
        end
        else
        begin
            if (cmd.upd_window)
            begin
                sum_reg[fidx_reg]  <= sum_reg[fidx_reg] - SUM_W'(old_val) + SUM_W'(v_reg);
                seen_reg[fidx_reg] <= 1'b1;
                if (pos_reg[fidx_reg] == POS_LAST)
                begin
                    pos_reg[fidx_reg]     <= '0;
                    wrapped_reg[fidx_reg] <= 1'b1;
                end
                else
                begin
                    pos_reg[fidx_reg] <= pos_reg[fidx_reg] + 1'b1;
                end
                // First sample sets both extremes.
                if (!seen_before_reg || v_reg < min_reg[fidx_reg])
                begin
                    min_reg[fidx_reg] <= v_reg;
                end
                if (!seen_before_reg || v_reg > max_reg[fidx_reg])
                begin
                    max_reg[fidx_reg] <= v_reg;
                end
            end
            if (cmd.upd_square)
            begin
                sq_reg[fidx_reg] <= sq_sum_full[SQ_W-1:0];
            end
            if (cmd.emit && ok_reg)
            begin
                run_reg[fidx_reg]   <= run_new;
                total_reg[fidx_reg] <= total_new;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_feature_reg <= feature_reg;
            out_spread_reg  <= spread;
            out_anom_reg    <= spread & anom_reg;
            out_alert_reg   <= spread & alert_reg;
            if (ok_reg)
            begin
                out_run_reg   <= run_new;
                out_total_reg <= total_new;
                out_min_reg   <= swzd_pkg::SAMPLE_W'(min_reg[fidx_reg]);
                out_max_reg   <= swzd_pkg::SAMPLE_W'(max_reg[fidx_reg]);
            end
            else
            begin
                out_run_reg   <= '0;
                out_total_reg <= '0;
                out_min_reg   <= '0;
                out_max_reg   <= '0;
            end
        end
    end

    assign result_ch.valid          = out_valid_reg;
    assign result_ch.feature_echo   = out_feature_reg;
    assign result_ch.spread_present = out_spread_reg;
    assign result_ch.model_anomaly  = out_anom_reg;
    assign result_ch.alert          = out_alert_reg;
    assign result_ch.run_length     = out_run_reg;
    assign result_ch.anomaly_total  = out_total_reg;
    assign result_ch.smallest_seen  = out_min_reg;
    assign result_ch.largest_seen   = out_max_reg;

endmodule

`default_nettype wire

// File: rtl/sliding_window_zscore_detector.sv
// Sliding-window z-score detector, top level: APB thresholds, controller, datapath.
// A beat steps through the read, square, variance, deviation, model and alert
// states to the output state (an out-of-range feature goes straight there); the next beat
// is taken only back in idle, as the seven products share the single multiplier.
// Reset clears all statistics at once; the window needs no clearing pass, as
// a per-feature wrap flag makes unwritten slots read as zero.
`default_nettype none

module sliding_window_zscore_detector #(
    parameter int WINDOW_DEPTH  = 128,
    parameter int FEATURE_COUNT = 8,
    parameter int SAMPLE_BITS   = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    swzd_item_if.sink                            item_ch,
    swzd_result_if.source                        result_ch,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [swzd_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [swzd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [swzd_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    logic [swzd_pkg::THR_W-1:0] model_thr_reg;
    logic [swzd_pkg::THR_W-1:0] alert_thr_reg;
    swzd_pkg::cmd_t             cmd;
    swzd_pkg::status_t          status;
    logic                       item_ready;

    // Threshold registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_thr_reg <= swzd_pkg::THR_RESET;
            alert_thr_reg <= swzd_pkg::THR_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                swzd_pkg::REG_MODEL_THR: model_thr_reg <= pwdata[swzd_pkg::THR_W-1:0];
                swzd_pkg::REG_ALERT_THR: alert_thr_reg <= pwdata[swzd_pkg::THR_W-1:0];
                default:                 model_thr_reg <= model_thr_reg;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (paddr[2])
            swzd_pkg::REG_MODEL_THR: prdata = swzd_pkg::APB_DATA_W'(model_thr_reg);
            swzd_pkg::REG_ALERT_THR: prdata = swzd_pkg::APB_DATA_W'(alert_thr_reg);
            default:                 prdata = '0;
        endcase
    end

    assign pready        = 1'b1;
    assign item_ch.ready = item_ready;

    swzd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_ch.valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    swzd_datapath #(
        .WINDOW_DEPTH  (WINDOW_DEPTH),
        .FEATURE_COUNT (FEATURE_COUNT),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .feature         (item_ch.feature),
        .sample          (item_ch.sample),
        .model_threshold (model_thr_reg),
        .alert_threshold (alert_thr_reg),
        .cmd             (cmd),
        .status          (status),
        .result_ch       (result_ch)
    );

endmodule

`default_nettype wire

// File: tb/sv/tb_swzd_checker.sv
// Scoreboard for the sliding-window z-score detector: watches the item, result
// and APB channels, predicts every result and compares it field by field.
// Depends on swzd_pkg and the stream interfaces in swzd_stream_if.sv.
module tb_swzd_checker
    import swzd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    swzd_item_if                  item_ch,
    swzd_result_if                result_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    fail_count,
    output int                    pending,
    output int                    anomaly_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH    = 128;
    localparam int FEATURES = 8;

    typedef struct {
        logic [FEATURE_W-1:0] feature_echo;
        logic                 spread_present;
        logic                 model_anomaly;
        logic                 alert;
        logic [RUN_W-1:0]     run_length;
        logic [TOTAL_W-1:0]   anomaly_total;
        logic [SAMPLE_W-1:0]  smallest_seen;
        logic [SAMPLE_W-1:0]  largest_seen;
    } verdict_t;

    // Shadow copy of the detector's thresholds and per-feature statistics
    logic [THR_W-1:0]    model_thr;
    logic [THR_W-1:0]    alert_thr;
    logic [SAMPLE_W-1:0] window_copy [FEATURES][DEPTH];
    logic [22:0]         sum_copy [FEATURES];
    logic [38:0]         sumsq_copy [FEATURES];
    int unsigned         wr_pos [FEATURES];
    bit                  seen [FEATURES];
    logic [SAMPLE_W-1:0] min_copy [FEATURES];
    logic [SAMPLE_W-1:0] max_copy [FEATURES];
    logic [RUN_W-1:0]    run_copy [FEATURES];
    logic [TOTAL_W-1:0]  total_copy [FEATURES];

    verdict_t verdict_q[$];

    // Works out the result of one sample and updates the shadow state.
    function automatic verdict_t score_sample(logic [FEATURE_W-1:0] f, logic [SAMPLE_W-1:0] v);
        verdict_t     r;
        logic [15:0]  old;
        logic [127:0] variance;
        logic [127:0] dev;
        logic [127:0] nv;
        logic [127:0] lhs;
        int unsigned  pos;
        r = '{default: '0};
        r.feature_echo = f;
        if (!seen[f]) begin
            for (int i = 0; i < DEPTH; i++)
                window_copy[f][i] = '0;
            window_copy[f][0] = v;
            wr_pos[f] = 1;
            sum_copy[f] = 23'(v);
            sumsq_copy[f] = 39'(v) * 39'(v);
            min_copy[f] = v;
            max_copy[f] = v;
            seen[f] = 1'b1;
        end
        else begin
            pos = wr_pos[f];
            old = window_copy[f][pos];
            window_copy[f][pos] = v;
            sum_copy[f] = sum_copy[f] - 23'(old) + 23'(v);
            sumsq_copy[f] = sumsq_copy[f] - 39'(old) * 39'(old) + 39'(v) * 39'(v);
            wr_pos[f] = (pos + 1) % DEPTH;
            if (v < min_copy[f]) min_copy[f] = v;
            if (v > max_copy[f]) max_copy[f] = v;
            variance = 128'(DEPTH) * 128'(sumsq_copy[f]) - 128'(sum_copy[f]) * 128'(sum_copy[f]);
            if (variance != 0) begin
                r.spread_present = 1'b1;
                nv = 128'(DEPTH) * 128'(v);
                dev = (nv >= 128'(sum_copy[f])) ? nv - 128'(sum_copy[f])
                                                : 128'(sum_copy[f]) - nv;
                lhs = 128'(256) * dev * dev;
                if (lhs > variance * 128'(model_thr) * 128'(model_thr)) begin
                    r.model_anomaly = 1'b1;
                    if (run_copy[f] != '1) run_copy[f]++;
                    if (total_copy[f] != '1) total_copy[f]++;
                end
                else begin
                    run_copy[f] = '0;
                end
                r.alert = lhs > variance * 128'(alert_thr) * 128'(alert_thr);
            end
        end
        r.run_length = run_copy[f];
        r.anomaly_total = total_copy[f];
        r.smallest_seen = min_copy[f];
        r.largest_seen = max_copy[f];
        return r;
    endfunction

    function automatic void check_field(string name, longint unsigned exp, longint unsigned act);
        if (exp !== act) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp, act);
            fail_count++;
        end
    endfunction

    // Track thresholds, predict on every item beat and compare on every result beat
    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n) begin
            model_thr = THR_RESET;
            alert_thr = THR_RESET;
            for (int f = 0; f < FEATURES; f++)
            begin
                for (int i = 0; i < DEPTH; i++)
                    window_copy[f][i] = '0;
                sum_copy[f] = '0;
                sumsq_copy[f] = '0;
                wr_pos[f] = 0;
                seen[f] = 1'b0;
                min_copy[f] = '0;
                max_copy[f] = '0;
                run_copy[f] = '0;
                total_copy[f] = '0;
            end
            verdict_q.delete();
            pending = 0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_ALERT_THR)
                    alert_thr = pwdata[THR_W-1:0];
                else
                    model_thr = pwdata[THR_W-1:0];
            end
            if (item_ch.valid && item_ch.ready)
                verdict_q.push_back(score_sample(item_ch.feature, item_ch.sample));
            if (result_ch.valid && result_ch.ready) begin
                if (verdict_q.size() == 0) begin
                    $error("result beat for feature %0d with nothing expected",
                           result_ch.feature_echo);
                    fail_count++;
                end
                else begin
                    want = verdict_q.pop_front();
                    if (result_ch.model_anomaly) anomaly_seen++;
                    check_field("feature_echo", want.feature_echo, result_ch.feature_echo);
                    check_field("spread_present", want.spread_present, result_ch.spread_present);
                    check_field("model_anomaly", want.model_anomaly, result_ch.model_anomaly);
                    check_field("alert", want.alert, result_ch.alert);
                    check_field("run_length", want.run_length, result_ch.run_length);
                    check_field("anomaly_total", want.anomaly_total, result_ch.anomaly_total);
                    check_field("smallest_seen", want.smallest_seen, result_ch.smallest_seen);
                    check_field("largest_seen", want.largest_seen, result_ch.largest_seen);
                end
            end
            pending = verdict_q.size();
        end
    end

    initial
    begin
        fail_count = 0;
        anomaly_seen = 0;
        pending = 0;
    end

endmodule

// File: tb/sv/tb_top.sv
// Top of the detector testbench: clock, reset, APB threshold writes, sample
// stimulus with idle and stall phases, watchdog and verdict.
// Depends on swzd_pkg, the stream interfaces and tb_swzd_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import swzd_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD   = 300;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending;
    int anomaly_seen;
    int sender_idle_pct;
    int receiver_stall_pct;
    bit hold_request;
    int hold_left;
    int items_sent;
    int quiet_cycles;
    logic [SAMPLE_W-1:0] baseline [8];

    swzd_item_if   item_ch ();
    swzd_result_if result_ch ();

    sliding_window_zscore_detector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_ch   (item_ch.sink),
        .result_ch (result_ch.source),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    tb_swzd_checker scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_ch      (item_ch),
        .result_ch    (result_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .anomaly_seen (anomaly_seen)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(negedge clk)
    begin
        if (hold_request) begin
            hold_left = LONG_HOLD;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else begin
            result_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Watchdog: cycles in which no beat and no register access happen
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
            || psel || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_threshold(logic reg_index, logic [THR_W-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {reg_index, 2'b00};
        pwdata <= APB_DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Offer one beat after a random gap and wait until it is taken
    task automatic send_sample(logic [FEATURE_W-1:0] f, logic [SAMPLE_W-1:0] s);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.feature <= f;
        item_ch.sample <= s;
        do
            @(posedge clk);
        while (!item_ch.ready);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic stop_sending();
        item_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Wait for every expected result, then let the pipeline drain
    task automatic drain();
        stop_sending();
        while (pending != 0)
            @(negedge clk);
        repeat (15) @(negedge clk);
    endtask

    // Mostly noise around a per-feature baseline, with spikes and wild values
    task automatic send_random_sample();
        logic [FEATURE_W-1:0] f;
        int                   s;
        int                   pick;
        f = ($urandom_range(3) == 0) ? FEATURE_W'($urandom_range(7))
                                     : FEATURE_W'($urandom_range(2));
        pick = $urandom_range(99);
        if (pick < 60)
            s = int'(baseline[f]) + $urandom_range(64) - 32;
        else if (pick < 75)
            s = baseline[f];
        else if (pick < 90)
            s = (baseline[f] < 16'h8000) ? int'(baseline[f]) + $urandom_range(32768, 1000)
                                          : int'(baseline[f]) - $urandom_range(32768, 1000);
        else
            s = $urandom_range(65535);
        if (s < 0) s = 0;
        if (s > 65535) s = 65535;
        send_sample(f, SAMPLE_W'(s));
    endtask

    logic [THR_W-1:0] model_setting [6] = '{8'd0, 8'd255, 8'd16, 8'd40, 8'd1, 8'd48};
    logic [THR_W-1:0] alert_setting [6] = '{8'd255, 8'd0, 8'd40, 8'd16, 8'd254, 8'd48};

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        item_ch.valid = 1'b0;
        item_ch.feature = '0;
        item_ch.sample = '0;
        result_ch.ready = 1'b0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_request = 1'b0;
        hold_left = 0;
        items_sent = 0;
        quiet_cycles = 0;
        for (int f = 0; f < 8; f++)
            baseline[f] = SAMPLE_W'($urandom_range(65535));
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: first samples, zero spread, spikes and field extremes
        send_sample(3'd0, 16'd0);
        send_sample(3'd0, 16'd0);
        send_sample(3'd0, 16'd0);
        send_sample(3'd0, 16'hFFFF);
        send_sample(3'd0, 16'hFFFF);
        send_sample(3'd0, 16'd0);
        send_sample(3'd7, 16'hFFFF);
        send_sample(3'd7, 16'h0001);
        send_sample(3'd7, 16'h5555);
        send_sample(3'd7, 16'hAAAA);
        send_sample(3'd5, 16'd1234);
        send_sample(3'd5, 16'd1234);
        send_sample(3'd5, 16'd1234);
        send_sample(3'd2, 16'd100);
        send_sample(3'd3, 16'd9);
        send_sample(3'd4, 16'd60000);
        send_sample(3'd6, 16'd0);
        send_sample(3'd6, 16'd1);
        send_sample(3'd1, 16'hFFFF);
        send_sample(3'd1, 16'd0);
        drain();

        // Random phases, one threshold pair and idle mode per phase
        for (int phase = 0; phase < 6; phase++)
        begin
            write_threshold(REG_MODEL_THR, model_setting[phase]);
            write_threshold(REG_ALERT_THR, alert_setting[phase]);
            case (phase % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 51; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 51; end
                default: begin sender_idle_pct = 34; receiver_stall_pct = 34; end
            endcase
            for (int n = 0; n < 155; n++)
            begin
                if (phase == 0 && n == 40)
                    hold_request = 1'b1;
                if (phase == 2 && n == 80)
                    drain();
                send_random_sample();
            end
            drain();
        end

        $display("Covered %0d samples over six threshold pairs from 0 to 255, %0d anomalies,",
                 items_sent, anomaly_seen);
        $display("with idle and stall phases, a long result hold-off and a full drain.");
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
